>>> rtl/core/indexed_ordered_list_unit_assert.svh
// assertion macros for the ordered list unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define IOLU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IOLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/iolu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ordered list unit
// no dependencies
package iolu_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

    typedef enum logic [2:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_AT   = 3'd2,
        CMD_DEL_HEAD = 3'd3,
        CMD_DEL_TAIL = 3'd4,
        CMD_DEL_AT   = 3'd5,
        CMD_READ_AT  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADIDX = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_COPY = 2'd1,
        S_READ = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic [2:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        t_status                 status;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]        entry_count;
    } t_out;

    // decode of an accepted command
    typedef struct packed {
        t_status          status;
        logic             go_copy;
        logic             go_read;
        logic             insert;
        logic [ADDR_W-1:0] at;
        logic [CNT_W-1:0] left;
        logic [ADDR_W-1:0] first;
        logic [CNT_W-1:0] count;
        logic signed [DATA_W-1:0] rdval;
    } t_dec;

endpackage

>>> rtl/core/indexed_ordered_list_unit.sv
`timescale 1ns / 1ps
// ordered list of signed values kept in one ram, shifted entry by entry
// depends on iolu_pkg, iolu_ram and indexed_ordered_list_unit_assert.svh
//
//  channel   dir   payload   handshake
//  in        in    t_in      i_in_valid / o_in_stall
//  out       out   t_out     o_out_valid / i_out_stall
//
// an insert, or a delete not at the tail, shifts the entries past its index
// in S_COPY, one entry per cycle via the ram's single read and write port
// a read goes via S_READ, a refused or trivial command skips to S_DONE
// reset is synchronous and clears the count; the ram needs no clearing
// a new command is taken while a result still waits at the output register

module indexed_ordered_list_unit
    import iolu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_insert, n_insert;
    logic [ADDR_W-1:0] r_at, n_at;
    logic signed [DATA_W-1:0] r_val, n_val;
    t_status           r_status, n_status;
    logic signed [DATA_W-1:0] r_rdval, n_rdval;
    logic [CNT_W-1:0]  r_count_n, n_count_n;

    logic              in_xfer;
    logic              out_free;
    t_dec              dec;
    logic [CNT_W-1:0]  ins_at;
    logic [CNT_W-1:0]  del_at;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    iolu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // command decode against the current count
    always_comb begin
        dec         = '0;
        dec.status  = ST_OK;
        dec.count   = r_count;
        dec.first   = ADDR_W'(r_count - CNT_W'(1));
        ins_at      = '0;
        del_at      = '0;
        case (i_in.command)
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                if (i_in.command == CMD_INS_HEAD) begin
                    ins_at = '0;
                end else if (i_in.command == CMD_INS_TAIL) begin
                    ins_at = r_count;
                end else begin
                    ins_at = i_in.position;
                end
                if (ins_at > r_count) begin
                    dec.status = ST_BADIDX;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    dec.status = ST_FULL;
                end else begin
                    dec.go_copy = 1'b1;
                    dec.insert  = 1'b1;
                    dec.at      = ins_at[ADDR_W-1:0];
                    dec.left    = r_count - ins_at;
                    dec.count   = r_count + CNT_W'(1);
                end
            end
            CMD_DEL_HEAD, CMD_DEL_AT: begin
                del_at = (i_in.command == CMD_DEL_HEAD) ? '0 : i_in.position;
                if (i_in.command == CMD_DEL_HEAD && r_count == '0) begin
                    dec.status = ST_EMPTY;
                end else if (del_at >= r_count) begin
                    dec.status = ST_BADIDX;
                end else begin
                    dec.go_copy = 1'b1;
                    dec.at      = del_at[ADDR_W-1:0];
                    dec.left    = r_count - CNT_W'(1) - del_at;
                    dec.first   = ADDR_W'(del_at + CNT_W'(1));
                    dec.count   = r_count - CNT_W'(1);
                end
            end
            CMD_DEL_TAIL: begin
                if (r_count == '0) begin
                    dec.status = ST_EMPTY;
                end else begin
                    dec.count = r_count - CNT_W'(1);
                end
            end
            CMD_READ_AT: begin
                if (i_in.position >= r_count) begin
                    dec.status = ST_BADIDX;
                    dec.rdval  = READ_MISS;
                end else begin
                    dec.go_read = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (dec.go_copy) begin
                        n_state = S_COPY;
                    end else if (dec.go_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COPY: begin
                if (r_left == '0 && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ram control and datapath
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_insert    = r_insert;
        n_at        = r_at;
        n_val       = r_val;
        n_status    = r_status;
        n_rdval     = r_rdval;
        n_count_n   = r_count_n;
        ram_we      = 1'b0;
        ram_waddr   = r_pend_addr;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_rd_addr;
        case (r_state)
            S_IDLE: begin
                ram_raddr = i_in.position[ADDR_W-1:0];
                if (in_xfer) begin
                    n_status  = dec.status;
                    n_rdval   = dec.rdval;
                    n_count_n = dec.count;
                    n_insert  = dec.insert;
                    n_at      = dec.at;
                    n_left    = dec.left;
                    n_rd_addr = dec.first;
                    n_val     = i_in.item_value;
                end
            end
            S_COPY: begin
                // data read last cycle lands one place over
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_addr;
                    ram_wdata = ram_rdata;
                end
                if (r_left != '0) begin
                    ram_raddr = r_rd_addr;
                    n_pend    = 1'b1;
                    n_left    = r_left - CNT_W'(1);
                    if (r_insert) begin
                        n_pend_addr = r_rd_addr + ADDR_W'(1);
                        n_rd_addr   = r_rd_addr - ADDR_W'(1);
                    end else begin
                        n_pend_addr = r_rd_addr - ADDR_W'(1);
                        n_rd_addr   = r_rd_addr + ADDR_W'(1);
                    end
                end else if (!r_pend && r_insert) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_at;
                    ram_wdata = r_val;
                end
            end
            S_READ: begin
                n_rdval = ram_rdata;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.read_value  = r_rdval;
                    n_out.entry_count = r_count_n;
                    n_count           = r_count_n;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_pend_addr <= n_pend_addr;
        r_rd_addr   <= n_rd_addr;
        r_left      <= n_left;
        r_insert    <= n_insert;
        r_at        <= n_at;
        r_val       <= n_val;
        r_status    <= n_status;
        r_rdval     <= n_rdval;
        r_count_n   <= n_count_n;
    end

`include "indexed_ordered_list_unit_assert.svh"

    `IOLU_ASSERT_NOW(a_no_overlap, (r_state == S_COPY && r_pend && r_left != '0), (r_pend_addr != r_rd_addr), "shift read and write hit the same entry")
    `IOLU_ASSERT_NEXT(a_busy_after_xfer, in_xfer, (r_state != S_IDLE), "block idle right after a transfer")
    `IOLU_ASSERT_NOW(a_count_bound, 1'b1, (r_count <= CNT_W'(CAPACITY)), "entry count beyond capacity")
    `IOLU_ASSERT_NOW(a_single_write, (r_state != S_COPY), (!ram_we), "ram written outside a shift")

endmodule

>>> rtl/core/iolu_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module iolu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sim/tb_indexed_ordered_list_unit.sv
`timescale 1ns / 1ps
// self-checking bench for indexed_ordered_list_unit: directed corner commands, then random
// fill, drain and mixed phases, each reply checked against a shadow copy of the list
// depends on iolu_pkg and the indexed_ordered_list_unit rtl
module tb_indexed_ordered_list_unit;
    import iolu_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_CMDS = 1225;
    localparam int QUIET_TAIL  = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 100;
    localparam int MODE_FILL   = 0;
    localparam int MODE_DRAIN  = 1;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_cmd;
    logic out_valid;
    logic out_stall;
    t_out out_reply;

    indexed_ordered_list_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_cmd),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_reply)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    t_in  cmd_backlog[$];
    t_out awaited_replies[$];
    int   fail_count;
    int   gen_count;
    int   in_gap;
    int   out_gap;
    int   quiet_cycles;

    // shadow copy of the list
    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int list_len;

    function automatic t_status list_insert(input int at, input logic signed [DATA_W-1:0] v);
        if (at > list_len) return ST_BADIDX;
        if (list_len >= CAPACITY) return ST_FULL;
        for (int k = list_len; k > at; k--) list_vals[k] = list_vals[k - 1];
        list_vals[at] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic void list_remove(input int at);
        for (int k = at; k + 1 < list_len; k++) list_vals[k] = list_vals[k + 1];
        list_len--;
    endfunction

    function automatic t_out apply_list_cmd(input t_in x);
        t_out r;
        r.status     = ST_OK;
        r.read_value = '0;
        case (x.command)
            CMD_INS_HEAD: r.status = list_insert(0, x.item_value);
            CMD_INS_TAIL: r.status = list_insert(list_len, x.item_value);
            CMD_INS_AT:   r.status = list_insert(int'(x.position), x.item_value);
            CMD_DEL_HEAD: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_remove(0);
            end
            CMD_DEL_TAIL: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            CMD_DEL_AT: begin
                if (int'(x.position) >= list_len) r.status = ST_BADIDX;
                else list_remove(int'(x.position));
            end
            CMD_READ_AT: begin
                if (int'(x.position) >= list_len) begin
                    r.status     = ST_BADIDX;
                    r.read_value = READ_MISS;
                end else begin
                    r.read_value = list_vals[int'(x.position)];
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(list_len);
        return r;
    endfunction

    // only the count is tracked at generation time, to aim indexes at live entries
    function automatic int count_after(input logic [2:0] c, input int p, input int n);
        case (c)
            CMD_INS_HEAD, CMD_INS_TAIL: return (n < CAPACITY) ? n + 1 : n;
            CMD_INS_AT:   return (p <= n && n < CAPACITY) ? n + 1 : n;
            CMD_DEL_HEAD, CMD_DEL_TAIL: return (n > 0) ? n - 1 : n;
            CMD_DEL_AT:   return (p < n) ? n - 1 : n;
            default:      return n;
        endcase
    endfunction

    task automatic queue_cmd(input logic [2:0] c, input int p, input logic [DATA_W-1:0] v);
        t_in x;
        x.command    = c;
        x.position   = POS_W'(p);
        x.item_value = v;
        cmd_backlog.push_back(x);
        gen_count = count_after(c, p, gen_count);
    endtask

    // idling is on in long stretches, with quiet ones between and at the end
    function automatic bit idling_allowed();
        return cmd_backlog.size() > QUIET_TAIL && (cmd_backlog.size() / 64) % 3 != 0;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_proc
        logic nxt_valid;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_cmd   <= '0;
            in_gap   = 0;
        end else begin
            nxt_valid = in_valid;
            if (in_valid && !in_stall) begin
                awaited_replies.push_back(apply_list_cmd(in_cmd));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && cmd_backlog.size() > 0) begin
                if (in_gap == 0 && idling_allowed() && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 4);
                if (in_gap > 0) begin
                    in_gap--;
                end else begin
                    nxt_valid = 1'b1;
                    in_cmd <= cmd_backlog.pop_front();
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_proc
        t_out want;
        logic nxt_stall;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            out_gap   = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply with nothing awaited: status %0d value %0d count %0d",
                           out_reply.status, out_reply.read_value, out_reply.entry_count);
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (out_reply.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, out_reply.status);
                        fail_count++;
                    end
                    if (out_reply.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               want.read_value, out_reply.read_value);
                        fail_count++;
                    end
                    if (out_reply.entry_count !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, got %0d",
                               want.entry_count, out_reply.entry_count);
                        fail_count++;
                    end
                end
            end
            nxt_stall = 1'b0;
            if (out_gap == 0 && idling_allowed() && $urandom_range(0, 5) == 0)
                out_gap = $urandom_range(1, 4);
            if (out_gap > 0) begin
                nxt_stall = 1'b1;
                out_gap--;
            end
            out_stall <= nxt_stall;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int mode;
        int seg_left;
        int ins_share;
        int r;
        int pos;
        logic [2:0] c;
        logic [DATA_W-1:0] v;

        fail_count = 0;
        gen_count  = 0;
        list_len   = 0;
        seg_left   = 0;
        mode       = MODE_FILL;
        i_rst_n    = 1'b0;

        // empty list corners
        queue_cmd(CMD_READ_AT, 0, 32'h1234_5678);
        queue_cmd(CMD_DEL_HEAD, 0, '0);
        queue_cmd(CMD_DEL_TAIL, 0, '0);
        queue_cmd(CMD_DEL_AT, 0, '0);
        queue_cmd(CMD_INS_AT, 1, 32'h0000_0011);
        // value extremes, position ignored on head and tail commands
        queue_cmd(CMD_INS_HEAD, 127, 32'h7fff_ffff);
        queue_cmd(CMD_INS_TAIL, 127, 32'h8000_0000);
        // index equal to the count appends at the tail
        queue_cmd(CMD_INS_AT, 2, 32'hffff_ffff);
        queue_cmd(CMD_INS_AT, 0, 32'h0000_0000);
        queue_cmd(CMD_INS_AT, 1, 32'h5555_5555);
        queue_cmd(CMD_INS_AT, 6, 32'h0000_0022);
        queue_cmd(CMD_READ_AT, 0, '0);
        queue_cmd(CMD_READ_AT, 1, '0);
        queue_cmd(CMD_READ_AT, 4, '0);
        queue_cmd(CMD_READ_AT, 5, '0);
        queue_cmd(CMD_READ_AT, 127, '0);
        queue_cmd(CMD_UNUSED, 85, 32'hdead_beef);
        queue_cmd(CMD_DEL_AT, 2, '0);
        queue_cmd(CMD_DEL_AT, 4, '0);
        queue_cmd(CMD_DEL_HEAD, 42, '0);
        queue_cmd(CMD_DEL_TAIL, 42, '0);
        queue_cmd(CMD_READ_AT, 1, '0);
        queue_cmd(CMD_INS_HEAD, 0, 32'haaaa_aaaa);

        // random phases that fill the store up, drain it empty or mix
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(60, 150);
            end
            seg_left--;
            ins_share = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 10 : 50;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                c = CMD_UNUSED;
            end else if (r < 16) begin
                c = CMD_READ_AT;
            end else if ($urandom_range(0, 99) < ins_share) begin
                case ($urandom_range(0, 2))
                    0:       c = CMD_INS_HEAD;
                    1:       c = CMD_INS_TAIL;
                    default: c = CMD_INS_AT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       c = CMD_DEL_HEAD;
                    1:       c = CMD_DEL_TAIL;
                    default: c = CMD_DEL_AT;
                endcase
            end
            pos = $urandom_range(0, 127);
            if (c == CMD_INS_AT && $urandom_range(0, 9) != 0)
                pos = $urandom_range(0, gen_count);
            else if ((c == CMD_DEL_AT || c == CMD_READ_AT) && gen_count > 0
                     && $urandom_range(0, 9) != 0)
                pos = $urandom_range(0, gen_count - 1);
            v = $urandom();
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            queue_cmd(c, pos, v);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (cmd_backlog.size() > 0 || in_valid);
        do @(posedge i_clk); while (awaited_replies.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
